/* rtl/fpps_pkg.sv */
// Shared types and constants for the furthest point pair search block.
// No dependencies; every other file in rtl/ uses this package.
package fpps_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 16;

    // Fixed widths of the channel fields.
    localparam int IN_COORD_W = 16;
    localparam int IDX_W      = 8;
    localparam int DSQ_W      = 34;
    localparam int DIST_W     = 17;
    localparam int CNT_W      = 9;

    typedef struct packed {
        logic signed [IN_COORD_W-1:0] coord_x;
        logic signed [IN_COORD_W-1:0] coord_y;
        logic signed [IN_COORD_W-1:0] coord_z;
        logic                         last_point;
    } t_in_beat;

    typedef struct packed {
        logic [IDX_W-1:0]  first_index;
        logic [IDX_W-1:0]  second_index;
        logic [DSQ_W-1:0]  dist_squared;
        logic [DIST_W-1:0] pair_distance;
        logic [CNT_W-1:0]  point_count;
        logic              overflow;
    } t_out_beat;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic best_clear;
        logic scan_init;
        logic scan_issue;
        logic root_start;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_ge2;
        logic pair_last;
        logic pipe_busy;
        logic root_done;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/furthest_point_pair_search.sv */
// Top level of the furthest point pair search block.
// Depends on fpps_pkg, fpps_ctrl, fpps_datapath and fpps_isqrt.
//
// Usage: points arrive on the input channel, one beat each, and are written
// into the point memory. Points past MAX_POINTS are dropped and flag overflow.
// The beat with last_point set ends the group. The block then stalls the input
// channel, reads two memory ports per cycle and scores one pair i<j per cycle
// through a four-stage distance pipeline, keeping the first largest pair.
// An iterative square root unit then finds COORD_BITS+1 bits, one per cycle.
// Throughput: one point per cycle while loading. After the last beat the scan
// of the n*(n-1)/2 pairs of a group of n points sets the pace, at the memory
// read rate of one pair per cycle, before the square root and the result beat.
// A group of fewer than two points skips the scan.
// The result sits in an output register; the input channel opens again as
// soon as the result is registered, even while the receiver stalls it.
// A receiver stall only holds the result register, and the next group's
// result waits in the controller until that register is free.
// Reset (synchronous, active low) empties the group and the output register.
module furthest_point_pair_search #(
    parameter int MAX_POINTS = fpps_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = fpps_pkg::COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fpps_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fpps_pkg::t_out_beat o_out_beat
);
    import fpps_pkg::*;

    // Commands and status between the controller and the datapath.
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    fpps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_beat.last_point),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    fpps_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_beat   (i_in_beat),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

endmodule

/* rtl/fpps_isqrt.sv */
// Iterative integer square root, one result bit per cycle.
// Depends on fpps_pkg for its default width; used by fpps_datapath.
module fpps_isqrt #(
    parameter int IN_W = 2 * fpps_pkg::COORD_BITS_DEF + 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [IN_W-1:0]   i_value,
    output logic              o_done,
    output logic [IN_W/2-1:0] o_root
);
    localparam int RW = IN_W / 2;
    localparam int SW = $clog2(RW + 1);

    logic [IN_W-1:0] r_val;
    logic [RW+1:0]   r_rem;
    logic [RW-1:0]   r_root;
    logic [SW-1:0]   r_steps;
    logic            r_busy;
    logic            r_done;

    logic [RW+1:0]   w_rem_sh;
    logic [RW+1:0]   w_trial;
    logic            w_ge;

    // Bring down the next two bits and try to set the next root bit.
    assign w_rem_sh = {r_rem[RW-1:0], r_val[IN_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_steps == SW'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val   <= i_value;
            r_rem   <= '0;
            r_root  <= '0;
            r_steps <= SW'(RW);
        end else if (r_busy) begin
            r_rem   <= w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root  <= {r_root[RW-2:0], w_ge};
            r_val   <= {r_val[IN_W-3:0], 2'b00};
            r_steps <= r_steps - SW'(1);
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* rtl/fpps_datapath.sv */
// Datapath of the furthest point pair search: point memory, pair address
// counters, distance pipeline, best-pair registers and result register.
// Depends on fpps_pkg and fpps_isqrt.
module fpps_datapath #(
    parameter int MAX_POINTS = fpps_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = fpps_pkg::COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fpps_pkg::t_dp_cmd   i_cmd,
    input  fpps_pkg::t_in_beat  i_in_beat,
    output fpps_pkg::t_dp_sts   o_sts,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output fpps_pkg::t_out_beat o_out_beat
);
    import fpps_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int PW = 3 * COORD_BITS;
    localparam int DW = 2 * COORD_BITS + 2;
    localparam int RW = DW / 2;

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS:0] d;
        d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
        if (d[COORD_BITS]) begin
            d = -d;
        end
        return d[COORD_BITS-1:0];
    endfunction

    // Coordinates are kept at COORD_BITS, in x, y, z order.
    logic [PW-1:0] w_wr_data;

    if (COORD_BITS <= IN_COORD_W) begin : g_trunc
        assign w_wr_data = {i_in_beat.coord_x[COORD_BITS-1:0],
                            i_in_beat.coord_y[COORD_BITS-1:0],
                            i_in_beat.coord_z[COORD_BITS-1:0]};
    end else begin : g_ext
        assign w_wr_data = {{(COORD_BITS-IN_COORD_W){i_in_beat.coord_x[IN_COORD_W-1]}},
                            i_in_beat.coord_x,
                            {(COORD_BITS-IN_COORD_W){i_in_beat.coord_y[IN_COORD_W-1]}},
                            i_in_beat.coord_y,
                            {(COORD_BITS-IN_COORD_W){i_in_beat.coord_z[IN_COORD_W-1]}},
                            i_in_beat.coord_z};
    end

    // Point count and overflow flag.
    logic [CW-1:0] r_count;
    logic          r_drop;
    logic          w_room;

    assign w_room = (r_count < CW'(MAX_POINTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
        end else if (i_cmd.emit) begin
            r_count <= '0;
            r_drop  <= 1'b0;
        end else if (i_cmd.load) begin
            if (w_room) begin
                r_count <= r_count + CW'(1);
            end else begin
                r_drop <= 1'b1;
            end
        end
    end

    // Point memory: one write port, two registered read ports.
    logic [PW-1:0] r_mem [MAX_POINTS];
    logic [PW-1:0] r_rd_a;
    logic [PW-1:0] r_rd_b;
    logic [AW-1:0] r_pi;
    logic [AW-1:0] r_pj;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_room) begin
            r_mem[r_count[AW-1:0]] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_issue) begin
            r_rd_a <= r_mem[r_pi];
            r_rd_b <= r_mem[r_pj];
        end
    end

    // Pair address counters, i outer and j inner.
    logic [CW-1:0] w_cnt_m1;
    logic [CW-1:0] w_cnt_m2;
    logic          w_j_end;
    logic          w_pair_last;

    assign w_cnt_m1    = r_count - CW'(1);
    assign w_cnt_m2    = r_count - CW'(2);
    assign w_j_end     = (CW'(r_pj) == w_cnt_m1);
    assign w_pair_last = w_j_end && (CW'(r_pi) == w_cnt_m2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_pi <= '0;
            r_pj <= AW'(1);
        end else if (i_cmd.scan_issue) begin
            if (w_j_end) begin
                r_pi <= r_pi + AW'(1);
                r_pj <= r_pi + AW'(2);
            end else begin
                r_pj <= r_pj + AW'(1);
            end
        end
    end

    // Distance pipeline: read, absolute differences, squares, sum.
    logic                    r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic [AW-1:0]           r_s1_i, r_s1_j, r_s2_i, r_s2_j;
    logic [AW-1:0]           r_s3_i, r_s3_j, r_s4_i, r_s4_j;
    logic [COORD_BITS-1:0]   r_s2_d  [3];
    logic [2*COORD_BITS-1:0] r_s3_sq [3];
    logic [DW-1:0]           r_s4_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.scan_issue;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_i <= r_pi;
        r_s1_j <= r_pj;
        r_s2_i <= r_s1_i;
        r_s2_j <= r_s1_j;
        r_s3_i <= r_s2_i;
        r_s3_j <= r_s2_j;
        r_s4_i <= r_s3_i;
        r_s4_j <= r_s3_j;
        for (int k = 0; k < 3; k++) begin
            r_s2_d[k]  <= abs_diff(r_rd_a[PW-1-k*COORD_BITS -: COORD_BITS],
                                   r_rd_b[PW-1-k*COORD_BITS -: COORD_BITS]);
            r_s3_sq[k] <= r_s2_d[k] * r_s2_d[k];
        end
        r_s4_sum <= DW'(r_s3_sq[0]) + DW'(r_s3_sq[1]) + DW'(r_s3_sq[2]);
    end

    // Best pair; a strictly larger distance wins, so ties keep the earlier pair.
    logic [DW-1:0] r_best;
    logic [AW-1:0] r_best_i;
    logic [AW-1:0] r_best_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.best_clear) begin
            r_best   <= '0;
            r_best_i <= '0;
            r_best_j <= '0;
        end else if (r_s4_v && (r_s4_sum > r_best)) begin
            r_best   <= r_s4_sum;
            r_best_i <= r_s4_i;
            r_best_j <= r_s4_j;
        end
    end

    // Square root of the final distance.
    logic          w_root_done;
    logic [RW-1:0] w_root;

    fpps_isqrt #(
        .IN_W (DW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.root_start),
        .i_value (r_best),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    // Result register.
    logic      r_out_valid;
    t_out_beat r_out_beat;
    logic      w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_beat.first_index   <= IDX_W'(r_best_i);
            r_out_beat.second_index  <= IDX_W'(r_best_j);
            r_out_beat.dist_squared  <= DSQ_W'(r_best);
            r_out_beat.pair_distance <= DIST_W'(w_root);
            r_out_beat.point_count   <= CNT_W'(r_count);
            r_out_beat.overflow      <= r_drop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    assign o_sts.count_ge2 = (r_count >= CW'(2));
    assign o_sts.pair_last = w_pair_last;
    assign o_sts.pipe_busy = r_s1_v || r_s2_v || r_s3_v || r_s4_v;
    assign o_sts.root_done = w_root_done;
    assign o_sts.out_free  = w_out_free;

`ifndef ASSERT_OFF
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count exceeds capacity");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v |-> (r_s1_i < r_s1_j))
        else $error("pair issued out of order");

    a_best_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(i_cmd.best_clear)) |-> (r_best >= $past(r_best)))
        else $error("best distance decreased during a search");
`endif

endmodule

/* rtl/fpps_ctrl.sv */
// Controller of the furthest point pair search: load, scan, drain, root, emit.
// Depends on fpps_pkg; drives the datapath only through t_dp_cmd.
module fpps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_stall,
    output fpps_pkg::t_dp_cmd o_cmd,
    input  fpps_pkg::t_dp_sts i_sts
);
    import fpps_pkg::*;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_ROOT  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_load;

    assign w_load = i_in_valid && (r_state == S_LOAD);

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.load       = w_load;
        o_cmd.best_clear = w_load && i_in_last;
        unique case (r_state)
            S_LOAD: begin
                if (w_load && i_in_last) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_sts.count_ge2) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    o_cmd.root_start = 1'b1;
                    n_state          = S_ROOT;
                end
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.pair_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    o_cmd.root_start = 1'b1;
                    n_state          = S_ROOT;
                end
            end
            S_ROOT: begin
                if (i_sts.root_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_LOAD);

`ifndef ASSERT_OFF
    a_issue_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_issue |-> i_sts.count_ge2)
        else $error("pair scan with fewer than two points");

    a_root_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.root_start |-> !i_sts.pipe_busy)
        else $error("square root started before the pipeline drained");

    a_init_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_init |=> o_cmd.scan_issue)
        else $error("scan set up but no pair issued");
`endif

endmodule

/* dv/furthest_point_pair_search_test.sv */
// Self-checking testbench for furthest_point_pair_search: sends point groups, predicts the
// farthest pair of each group by exhaustive search and compares every result beat.
// Depends on fpps_pkg and the RTL of the block; it needs no other file.
module furthest_point_pair_search_test;

    import fpps_pkg::*;

    localparam int CAPACITY = MAX_POINTS_DEF;

    // A 256 point group scans 32640 pairs with the input stalled and nothing accepted,
    // and LONG_HOLD sets the deliberate output hold. The watchdog limit is
    // several times the sum of both.
    localparam int unsigned WATCHDOG_LIMIT = 200000;
    localparam int unsigned LONG_HOLD      = 4000;
    localparam int unsigned DRAIN_CYCLES   = 64;
    localparam int unsigned RANDOM_ITEMS   = 150;
    localparam int unsigned RANDOM_GROUPS  = 12;

    // How the coordinates of a random group are drawn.
    typedef enum int unsigned {
        MIX_WIDE,   // any 16 bit value
        MIX_TIGHT,  // -3..3, so that equal distances and ties are common
        MIX_EDGE    // the most negative and most positive values, zero and -1
    } t_coord_mix;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_beat  in_beat;
    logic      out_valid;
    logic      out_stall;
    t_out_beat out_beat;

    // Points of the group that is being loaded, and whether any were dropped.
    t_in_beat  group_points[$];
    bit        group_dropped;
    // Predicted farthest pairs, oldest first, waiting for their result beats.
    t_out_beat farthest_pairs[$];

    int unsigned error_count = 0;
    bit          send_idling = 1'b0;
    bit          stall_enable = 1'b0;
    bit          hold_req = 1'b0;
    bit          hold_active = 1'b0;

    always #5 clk = ~clk;

    furthest_point_pair_search u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic longint unsigned squared_gap(input t_in_beat a, input t_in_beat b);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'($signed(a.coord_x)) - longint'($signed(b.coord_x));
        dy = longint'($signed(a.coord_y)) - longint'($signed(b.coord_y));
        dz = longint'($signed(a.coord_z)) - longint'($signed(b.coord_z));
        return longint'(dx * dx + dy * dy + dz * dz);
    endfunction

    // Floor of the square root, one result bit at a time from the top.
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        int              b;
        root = 0;
        for (b = 17; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Scans every pair i<j in order; only a strictly larger distance takes over,
    // so the first pair found keeps a tie; under two points, indices and distances stay zero.
    function automatic t_out_beat find_farthest_pair();
        t_out_beat       res;
        longint unsigned best;
        longint unsigned d;
        int              i;
        int              j;
        int              best_i;
        int              best_j;
        best = 0;
        best_i = 0;
        best_j = 0;
        for (i = 0; i + 1 < group_points.size(); i++) begin
            for (j = i + 1; j < group_points.size(); j++) begin
                d = squared_gap(group_points[i], group_points[j]);
                if (d > best) begin
                    best = d;
                    best_i = i;
                    best_j = j;
                end
            end
        end
        res.first_index   = IDX_W'(best_i);
        res.second_index  = IDX_W'(best_j);
        res.dist_squared  = DSQ_W'(best);
        res.pair_distance = DIST_W'(floor_root(best));
        res.point_count   = CNT_W'(group_points.size());
        res.overflow      = group_dropped;
        return res;
    endfunction

    // Called once per accepted input beat.
    function automatic void absorb_point(input t_in_beat beat);
        if (group_points.size() < CAPACITY) begin
            group_points.push_back(beat);
        end else begin
            group_dropped = 1'b1;
        end
        if (beat.last_point) begin
            farthest_pairs.push_back(find_farthest_pair());
            group_points.delete();
            group_dropped = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Most gaps are zero or short, a few are long.
    function automatic int unsigned pick_gap(input bit enabled);
        int unsigned r;
        if (!enabled) begin
            return 0;
        end
        r = $urandom_range(99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 10);
    endfunction

    // Drives one point beat at a falling edge and returns at the rising edge that
    // accepts it. Valid stays high from one beat to the next when there is no gap.
    task automatic send_point(input t_in_beat beat);
        int unsigned gap;
        gap = pick_gap(send_idling);
        @(negedge clk);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge clk); while (in_stall);
        absorb_point(beat);
    endtask

    function automatic t_in_beat make_point(input logic signed [15:0] x,
                                            input logic signed [15:0] y,
                                            input logic signed [15:0] z,
                                            input logic last);
        t_in_beat beat;
        beat.coord_x    = x;
        beat.coord_y    = y;
        beat.coord_z    = z;
        beat.last_point = last;
        return beat;
    endfunction

    function automatic logic signed [15:0] pick_coord(input t_coord_mix mix);
        case (mix)
            MIX_TIGHT: begin
                return 16'(int'($urandom_range(6)) - 3);
            end
            MIX_EDGE: begin
                case ($urandom_range(3))
                    0:       return 16'sh8000;
                    1:       return 16'sh7fff;
                    2:       return 16'sh0000;
                    default: return 16'shffff;
                endcase
            end
            default: begin
                return 16'($urandom);
            end
        endcase
    endfunction

    task automatic send_group(input int unsigned n_points, input t_coord_mix mix);
        int unsigned k;
        for (k = 0; k < n_points; k++) begin
            send_point(make_point(pick_coord(mix), pick_coord(mix), pick_coord(mix),
                                  k == n_points - 1));
        end
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    function automatic int unsigned stall_length();
        if ($urandom_range(99) < 88) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(60, 15);
    endfunction

    // Stall is set once per falling edge. A requested hold keeps it high through
    // the loop here that counts to LONG_HOLD, whatever the rest of the bench does.
    initial begin : result_sink
        int unsigned held;
        int unsigned stretch;
        out_stall = 1'b0;
        @(negedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                hold_active = 1'b1;
                out_stall <= 1'b1;
                for (held = 0; held < LONG_HOLD; held++) @(posedge clk);
                hold_active = 1'b0;
                @(negedge clk);
            end else if (stall_enable && $urandom_range(3) == 0) begin
                stretch = stall_length();
                out_stall <= 1'b1;
                repeat (stretch) @(negedge clk);
            end else begin
                out_stall <= 1'b0;
                @(negedge clk);
            end
        end
    end

    // Every accepted result beat is matched against the oldest predicted pair.
    always @(posedge clk) begin : result_check
        t_out_beat want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (farthest_pairs.size() == 0) begin
                report_mismatch("result beat arrived with no group pending");
            end else begin
                want = farthest_pairs.pop_front();
                if (out_beat.first_index !== want.first_index) begin
                    report_mismatch($sformatf("first_index %0d, predicted %0d",
                                              out_beat.first_index, want.first_index));
                end
                if (out_beat.second_index !== want.second_index) begin
                    report_mismatch($sformatf("second_index %0d, predicted %0d",
                                              out_beat.second_index, want.second_index));
                end
                if (out_beat.dist_squared !== want.dist_squared) begin
                    report_mismatch($sformatf("dist_squared %0d, predicted %0d",
                                              out_beat.dist_squared, want.dist_squared));
                end
                if (out_beat.pair_distance !== want.pair_distance) begin
                    report_mismatch($sformatf("pair_distance %0d, predicted %0d",
                                              out_beat.pair_distance, want.pair_distance));
                end
                if (out_beat.point_count !== want.point_count) begin
                    report_mismatch($sformatf("point_count %0d, predicted %0d",
                                              out_beat.point_count, want.point_count));
                end
                if (out_beat.overflow !== want.overflow) begin
                    report_mismatch($sformatf("overflow %0b, predicted %0b",
                                              out_beat.overflow, want.overflow));
                end
            end
        end
    end

    // Ends the run when neither channel has moved a beat for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // A group of one point has no pair: all zeros with a count of one.
    task automatic test_lone_point();
        send_point(make_point(16'sh8000, 16'sh7fff, 16'sh0000, 1'b1));
    endtask

    // Opposite corners of the coordinate range give the largest squared distance.
    task automatic test_opposite_corners();
        send_point(make_point(16'sh8000, 16'sh8000, 16'sh8000, 1'b0));
        send_point(make_point(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1));
        send_point(make_point(16'sh7fff, 16'sh8000, 16'shffff, 1'b0));
        send_point(make_point(16'sh0000, 16'sh0001, 16'sh0100, 1'b0));
        send_point(make_point(16'sh8000, 16'sh7fff, 16'sh0000, 1'b1));
    endtask

    // Coincident points: no distance beats zero, so the indices stay at zero.
    task automatic test_identical_points();
        send_point(make_point(16'shffff, 16'shffff, 16'shffff, 1'b0));
        send_point(make_point(16'shffff, 16'shffff, 16'shffff, 1'b0));
        send_point(make_point(16'shffff, 16'shffff, 16'shffff, 1'b1));
    endtask

    // Corners of a square: both diagonals tie, and the one found first is kept.
    task automatic test_tied_pairs();
        send_point(make_point(16'sh0000, 16'sh0000, 16'sh0000, 1'b0));
        send_point(make_point(16'sh0100, 16'sh0000, 16'sh0000, 1'b0));
        send_point(make_point(16'sh0000, 16'sh0100, 16'sh0000, 1'b0));
        send_point(make_point(16'sh0100, 16'sh0100, 16'sh0000, 1'b1));
        // The farthest pair is a later one, so the winner does not start at index zero.
        send_point(make_point(16'sh0005, 16'sh0005, 16'sh0005, 1'b0));
        send_point(make_point(16'sh0005, 16'sh0005, 16'sh0005, 1'b0));
        send_point(make_point(16'sh0007, 16'sh0005, 16'sh0005, 1'b0));
        send_point(make_point(16'sh0003, 16'sh0005, 16'sh0005, 1'b1));
    endtask

    // Fills the memory and offers three more points; the last one carries the end
    // flag and is dropped itself, yet still starts the search.
    task automatic test_memory_full();
        send_group(CAPACITY + 3, MIX_WIDE);
        // The next group must start empty, with the overflow flag cleared.
        send_group(2, MIX_EDGE);
    endtask

    // The receiver holds off while several groups go in back to back, so the
    // output register and the held result fill and the input channel stalls.
    task automatic test_long_hold();
        int unsigned g;
        send_idling = 1'b0;
        // The last beat has been taken; valid must not linger while waiting.
        @(negedge clk);
        in_valid <= 1'b0;
        hold_req = 1'b1;
        while (!hold_active) @(posedge clk);
        for (g = 0; g < 4; g++) begin
            send_group(6, MIX_WIDE);
        end
        @(negedge clk);
        in_valid <= 1'b0;
        while (hold_active) @(posedge clk);
    endtask

    // Random groups, mostly small, some mid-sized and a few large, with idling
    // switched on and off per group on both sides.
    task automatic test_random_groups();
        int unsigned items;
        int unsigned groups;
        int unsigned n_points;
        int unsigned r;
        items = 0;
        groups = 0;
        while (items < RANDOM_ITEMS || groups < RANDOM_GROUPS) begin
            send_idling  = ($urandom_range(3) != 0);
            stall_enable = ($urandom_range(3) != 0);
            r = $urandom_range(99);
            if (r < 70) begin
                n_points = $urandom_range(8, 1);
            end else if (r < 95) begin
                n_points = $urandom_range(24, 9);
            end else begin
                n_points = $urandom_range(64, 25);
            end
            send_group(n_points, t_coord_mix'($urandom_range(2)));
            items += n_points;
            groups++;
        end
    endtask

    initial begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_beat  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idling  = 1'b1;
        stall_enable = 1'b1;
        test_lone_point();
        test_opposite_corners();
        test_identical_points();
        test_tied_pairs();
        test_memory_full();
        test_long_hold();
        test_random_groups();

        @(negedge clk);
        in_valid <= 1'b0;
        while (farthest_pairs.size() != 0) @(posedge clk);
        // The drain wait that follows catches any result beat that nobody predicted.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
